@@ hdl/rsbt_pkg.sv @@
`timescale 1ns / 1ps

package rsbt_pkg;

   // Default table sizes
   localparam int NUM_RESOURCES_DEF = 16;
   localparam int MAX_SUBRES_DEF    = 16;

   // Stored subresource count width (holds counts up to 127)
   localparam int CNT_W = 7;

   // Operation codes
   localparam logic [2:0] OP_TRACK   = 3'd0;
   localparam logic [2:0] OP_UNTRACK = 3'd1;
   localparam logic [2:0] OP_QUERY   = 3'd2;
   localparam logic [2:0] OP_SET     = 3'd3;
   localparam logic [2:0] OP_TRANS   = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNTRACKED = 3'd1;
   localparam logic [2:0] ST_RANGE     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_COUNT     = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] resource_key;
      logic [31:0] state_value;
      logic [3:0]  subresource_index;
      logic        all_subresources;
      logic [4:0]  subresource_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        tracked;
      logic [31:0] read_state;
      logic        barrier_valid;
      logic        barrier_all;
      logic [3:0]  barrier_subresource;
      logic [31:0] state_before;
      logic [31:0] state_after;
      logic        last;
   } rsp_type;

   // Per-entry metadata held in the lookup memory
   typedef struct packed {
      logic [31:0]      key;
      logic [31:0]      whole;
      logic             split;
      logic [CNT_W-1:0] cnt;
   } meta_type;

   // Metadata update from the sequencer
   typedef struct packed {
      logic     we;
      logic     set_valid;
      logic     clr_valid;
      meta_type meta;
   } meta_wr_type;

   // Lookup result flags
   typedef struct packed {
      logic done;
      logic hit;
      logic free_found;
   } lkp_stat_type;

endpackage

@@ hdl/resource_state_barrier_tracker.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Ports                              Payload
// request   in         req_valid req_ready req_data       rsbt_pkg::req_type
// response  out        rsp_valid rsp_ready rsp_data       rsbt_pkg::rsp_type
//
// An op is accepted, runs the key scan over the metadata memory and a decide step, then
// walks the subresources with a read and a check each for a split transition or a merge
// check, writes each subresource when a whole resource first splits, reads or writes a
// single subresource where one is named, and ends in a step that issues the last result.
// A new request is taken once the last result of the previous one is in the output register.
// Reset clears the valid bits at once; no clearing pass is needed.
// A stalled response holds the walk only where a further barrier must be issued.

module resource_state_barrier_tracker #(
   parameter int NUM_RESOURCES = rsbt_pkg::NUM_RESOURCES_DEF,
   parameter int MAX_SUBRES    = rsbt_pkg::MAX_SUBRES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rsbt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsbt_pkg::rsp_type rsp_data
);

   localparam int IW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int DEPTH = NUM_RESOURCES * MAX_SUBRES;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = rsbt_pkg::CNT_W;
   localparam logic [AW-1:0] MAX_A = AW'(MAX_SUBRES);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SUBRES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_EXEC  = 4'd2;
   localparam logic [3:0] S_WR1   = 4'd3;
   localparam logic [3:0] S_FILL  = 4'd4;
   localparam logic [3:0] S_WRD   = 4'd5;
   localparam logic [3:0] S_WCHK  = 4'd6;
   localparam logic [3:0] S_QWAIT = 4'd7;
   localparam logic [3:0] S_TCUR  = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   logic [3:0] state_ff, state_in;
   rsbt_pkg::req_type req_ff, req_in;
   logic [CW-1:0] i_ff, i_in;
   logic [4:0]    nb_ff, nb_in;
   logic [31:0]   s0_ff, s0_in;
   logic          uni_ff, uni_in;
   logic          walk_all_ff, walk_all_in;
   logic          hb_v_ff, hb_v_in;
   logic          hb_all_ff, hb_all_in;
   logic [3:0]    hb_sub_ff, hb_sub_in;
   logic [31:0]   hb_before_ff, hb_before_in;
   logic [31:0]   hb_after_ff, hb_after_in;
   logic [2:0]    status_ff, status_in;
   logic          trk_ff, trk_in;
   logic [31:0]   rdv_ff, rdv_in;
   rsbt_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;

   logic [31:0] sub_mem [DEPTH];
   logic [31:0] sd_ff;

   logic          lkp_start;
   rsbt_pkg::lkp_stat_type lkp_stat;
   logic [IW-1:0] hit_slot;
   logic [IW-1:0] free_slot;
   rsbt_pkg::meta_type m;
   rsbt_pkg::meta_wr_type mw;
   logic [IW-1:0] mw_slot;

   logic          sw_en;
   logic [AW-1:0] sw_addr;
   logic [31:0]   sw_data;
   logic          sr_en;
   logic [AW-1:0] sr_addr;
   logic          push;
   rsbt_pkg::rsp_type push_data;

   logic          out_free;
   logic [4:0]    cnt0;
   logic [CW-1:0] idx_c;
   logic          idx_ok;
   logic          last_sub;

   function automatic logic [AW-1:0] sub_addr(input logic [IW-1:0] slot,
                                              input logic [CW-1:0] sub);
      sub_addr = AW'(slot) * MAX_A + AW'(sub);
   endfunction

   rsbt_slot_lookup #(
      .NUM_RESOURCES (NUM_RESOURCES),
      .IW            (IW)
   ) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .start     (lkp_start),
      .key       (req_data.resource_key),
      .stat      (lkp_stat),
      .hit_slot  (hit_slot),
      .free_slot (free_slot),
      .hit_meta  (m),
      .wr        (mw),
      .wr_slot   (mw_slot)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign cnt0      = (req_ff.subresource_count == 5'd0) ? 5'd1 : req_ff.subresource_count;
   assign idx_c     = CW'(req_ff.subresource_index);
   assign idx_ok    = idx_c < m.cnt;
   assign last_sub  = (i_ff + 1'b1) >= m.cnt;

   // Sequence one op: scan, decide, walk subresources, issue results
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      i_in         = i_ff;
      nb_in        = nb_ff;
      s0_in        = s0_ff;
      uni_in       = uni_ff;
      walk_all_in  = walk_all_ff;
      hb_v_in      = hb_v_ff;
      hb_all_in    = hb_all_ff;
      hb_sub_in    = hb_sub_ff;
      hb_before_in = hb_before_ff;
      hb_after_in  = hb_after_ff;
      status_in    = status_ff;
      trk_in       = trk_ff;
      rdv_in       = rdv_ff;
      lkp_start    = 1'b0;
      mw           = '0;
      mw.meta      = m;
      mw_slot      = hit_slot;
      sw_en        = 1'b0;
      sw_addr      = sub_addr(hit_slot, i_ff);
      sw_data      = req_ff.state_value;
      sr_en        = 1'b0;
      sr_addr      = sub_addr(hit_slot, i_ff);
      push         = 1'b0;
      push_data    = '0;
      push_data.status     = status_ff;
      push_data.tracked    = trk_ff;
      push_data.read_state = rdv_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               lkp_start = 1'b1;
               hb_v_in   = 1'b0;
               nb_in     = '0;
               rdv_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (lkp_stat.done) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = rsbt_pkg::ST_OK;
            trk_in    = lkp_stat.hit;
            state_in  = S_FIN;
            if (req_ff.op <= rsbt_pkg::OP_TRANS && req_ff.resource_key == 32'd0) begin
               status_in = rsbt_pkg::ST_UNTRACKED;
               trk_in    = 1'b0;
            end else if (req_ff.op == rsbt_pkg::OP_TRACK) begin
               if ({2'b00, cnt0} > MAX_C) begin
                  status_in = rsbt_pkg::ST_COUNT;
               end else if (lkp_stat.hit || lkp_stat.free_found) begin
                  mw.we         = 1'b1;
                  mw.set_valid  = 1'b1;
                  mw.meta.key   = req_ff.resource_key;
                  mw.meta.whole = req_ff.state_value;
                  mw.meta.split = 1'b0;
                  mw.meta.cnt   = CW'(cnt0);
                  mw_slot       = lkp_stat.hit ? hit_slot : free_slot;
                  trk_in        = 1'b1;
               end else begin
                  status_in = rsbt_pkg::ST_FULL;
               end
            end else if (req_ff.op <= rsbt_pkg::OP_TRANS && !lkp_stat.hit) begin
               status_in = rsbt_pkg::ST_UNTRACKED;
            end else if (req_ff.op == rsbt_pkg::OP_UNTRACK) begin
               mw.clr_valid = 1'b1;
               trk_in       = 1'b0;
            end else if (req_ff.op == rsbt_pkg::OP_QUERY) begin
               rdv_in = m.whole;
               if (!req_ff.all_subresources && !idx_ok) begin
                  status_in = rsbt_pkg::ST_RANGE;
               end else if (!req_ff.all_subresources && m.split) begin
                  sr_en    = 1'b1;
                  sr_addr  = sub_addr(hit_slot, idx_c);
                  state_in = S_QWAIT;
               end
            end else if (req_ff.op == rsbt_pkg::OP_SET) begin
               if (req_ff.all_subresources) begin
                  mw.we         = 1'b1;
                  mw.meta.whole = req_ff.state_value;
                  mw.meta.split = 1'b0;
               end else if (idx_ok) begin
                  state_in = S_WR1;
               end else begin
                  status_in = rsbt_pkg::ST_RANGE;
               end
            end else if (req_ff.op == rsbt_pkg::OP_TRANS) begin
               if (req_ff.all_subresources) begin
                  if (m.split) begin
                     i_in        = '0;
                     walk_all_in = 1'b1;
                     state_in    = S_WRD;
                  end else if (m.whole != req_ff.state_value) begin
                     hb_v_in       = 1'b1;
                     hb_all_in     = 1'b1;
                     hb_sub_in     = 4'd0;
                     hb_before_in  = m.whole;
                     hb_after_in   = req_ff.state_value;
                     mw.we         = 1'b1;
                     mw.meta.whole = req_ff.state_value;
                     mw.meta.split = 1'b0;
                  end
               end else if (idx_ok) begin
                  if (m.split) begin
                     sr_en    = 1'b1;
                     sr_addr  = sub_addr(hit_slot, idx_c);
                     state_in = S_TCUR;
                  end else if (m.whole != req_ff.state_value) begin
                     hb_v_in      = 1'b1;
                     hb_all_in    = 1'b0;
                     hb_sub_in    = req_ff.subresource_index;
                     hb_before_in = m.whole;
                     hb_after_in  = req_ff.state_value;
                     state_in     = S_WR1;
                  end
               end else begin
                  status_in = rsbt_pkg::ST_RANGE;
               end
            end
         end
         S_QWAIT: begin
            rdv_in   = sd_ff;
            state_in = S_FIN;
         end
         S_TCUR: begin
            if (sd_ff != req_ff.state_value) begin
               hb_v_in      = 1'b1;
               hb_all_in    = 1'b0;
               hb_sub_in    = req_ff.subresource_index;
               hb_before_in = sd_ff;
               hb_after_in  = req_ff.state_value;
               state_in     = S_WR1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_WR1: begin
            // Write one subresource, then decide whether the entry stays split
            if (m.split) begin
               sw_en       = 1'b1;
               sw_addr     = sub_addr(hit_slot, idx_c);
               i_in        = '0;
               uni_in      = 1'b1;
               walk_all_in = 1'b0;
               state_in    = S_WRD;
            end else if (m.cnt == CW'(1) || m.whole == req_ff.state_value) begin
               mw.we         = 1'b1;
               mw.meta.whole = req_ff.state_value;
               mw.meta.split = 1'b0;
               state_in      = S_FIN;
            end else begin
               i_in     = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            // Expand a whole entry into per-subresource states
            sw_en   = 1'b1;
            sw_data = (i_ff == idx_c) ? req_ff.state_value : m.whole;
            if (last_sub) begin
               mw.we         = 1'b1;
               mw.meta.split = 1'b1;
               state_in      = S_FIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_WRD: begin
            sr_en    = 1'b1;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            if (walk_all_ff) begin
               if (sd_ff != req_ff.state_value && nb_ff < 5'd16) begin
                  if (hb_v_ff && !out_free) begin
                     // hold until the previous barrier can be issued
                     state_in = S_WCHK;
                  end else begin
                     if (hb_v_ff) begin
                        push                          = 1'b1;
                        push_data.barrier_valid       = 1'b1;
                        push_data.barrier_all         = hb_all_ff;
                        push_data.barrier_subresource = hb_sub_ff;
                        push_data.state_before        = hb_before_ff;
                        push_data.state_after         = hb_after_ff;
                     end
                     hb_v_in      = 1'b1;
                     hb_all_in    = 1'b0;
                     hb_sub_in    = i_ff[3:0];
                     hb_before_in = sd_ff;
                     hb_after_in  = req_ff.state_value;
                     nb_in        = nb_ff + 1'b1;
                     if (last_sub) begin
                        mw.we         = 1'b1;
                        mw.meta.whole = req_ff.state_value;
                        mw.meta.split = 1'b0;
                        state_in      = S_FIN;
                     end else begin
                        i_in     = i_ff + 1'b1;
                        state_in = S_WRD;
                     end
                  end
               end else if (last_sub) begin
                  mw.we         = 1'b1;
                  mw.meta.whole = req_ff.state_value;
                  mw.meta.split = 1'b0;
                  state_in      = S_FIN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_WRD;
               end
            end else begin
               // merge check against the first subresource
               if (i_ff == '0) begin
                  s0_in = sd_ff;
               end else if (sd_ff != s0_ff) begin
                  uni_in = 1'b0;
               end
               if (last_sub) begin
                  mw.we = 1'b1;
                  if (uni_in) begin
                     mw.meta.whole = s0_in;
                     mw.meta.split = 1'b0;
                  end else begin
                     mw.meta.split = 1'b1;
                  end
                  state_in = S_FIN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_WRD;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               push           = 1'b1;
               push_data.last = 1'b1;
               if (hb_v_ff) begin
                  push_data.barrier_valid       = 1'b1;
                  push_data.barrier_all         = hb_all_ff;
                  push_data.barrier_subresource = hb_sub_ff;
                  push_data.state_before        = hb_before_ff;
                  push_data.state_after         = hb_after_ff;
               end
               hb_v_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Subresource state memory
   always_ff @(posedge clock) begin
      if (sr_en) begin
         sd_ff <= sub_mem[sr_addr];
      end
      if (sw_en) begin
         sub_mem[sw_addr] <= sw_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hb_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hb_v_ff  <= hb_v_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      i_ff         <= i_in;
      nb_ff        <= nb_in;
      s0_ff        <= s0_in;
      uni_ff       <= uni_in;
      walk_all_ff  <= walk_all_in;
      hb_all_ff    <= hb_all_in;
      hb_sub_ff    <= hb_sub_in;
      hb_before_ff <= hb_before_in;
      hb_after_ff  <= hb_after_in;
      status_ff    <= status_in;
      trk_ff       <= trk_in;
      rdv_ff       <= rdv_in;
      if (push) begin
         rsp_ff <= push_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SCAN))
      else $error("accepted request did not start a scan");
   a_barrier_differs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.barrier_valid) |-> (rsp_data.state_before != rsp_data.state_after))
      else $error("barrier with equal before and after states");
   a_all_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.barrier_all) |-> rsp_data.last)
      else $error("all-subresources barrier not last");
   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.barrier_valid) |-> rsp_data.last)
      else $error("result without barrier not last");
`endif

endmodule

@@ hdl/rsbt_slot_lookup.sv @@
`timescale 1ns / 1ps

module rsbt_slot_lookup #(
   parameter int NUM_RESOURCES = rsbt_pkg::NUM_RESOURCES_DEF,
   parameter int IW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            key,
   output rsbt_pkg::lkp_stat_type stat,
   output logic [IW-1:0]          hit_slot,
   output logic [IW-1:0]          free_slot,
   output rsbt_pkg::meta_type     hit_meta,
   input  rsbt_pkg::meta_wr_type  wr,
   input  logic [IW-1:0]          wr_slot
);

   localparam logic [IW:0] NUM_L = (IW + 1)'(NUM_RESOURCES);

   rsbt_pkg::meta_type meta_mem [NUM_RESOURCES];
   rsbt_pkg::meta_type rd_ff;
   logic [NUM_RESOURCES-1:0] valid_ff;

   logic [IW:0]   cnt_ff;
   logic [IW-1:0] pidx_ff;
   logic          pend_ff;
   logic          active_ff;
   logic [31:0]   key_ff;
   logic          hit_ff;
   logic          free_ff;
   logic [IW-1:0] hit_slot_ff;
   logic [IW-1:0] free_slot_ff;
   rsbt_pkg::meta_type hit_meta_ff;

   logic issue;
   logic done;

   assign issue = active_ff && (cnt_ff != NUM_L);
   assign done  = active_ff && (cnt_ff == NUM_L) && !pend_ff;

   // Read metadata during the scan, write on update
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= meta_mem[cnt_ff[IW-1:0]];
      end
      if (wr.we) begin
         meta_mem[wr_slot] <= wr.meta;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.set_valid) begin
         valid_ff[wr_slot] <= 1'b1;
      end else if (wr.clr_valid) begin
         valid_ff[wr_slot] <= 1'b0;
      end
   end

   // Walk the table one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         cnt_ff    <= '0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
      end else if (start) begin
         active_ff <= 1'b1;
         pend_ff   <= 1'b0;
         cnt_ff    <= '0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         if (done) begin
            active_ff <= 1'b0;
         end
         pend_ff <= issue;
         if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (pend_ff) begin
            if (valid_ff[pidx_ff] && rd_ff.key == key_ff && key_ff != 32'd0 && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (!valid_ff[pidx_ff] && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
      end
   end

   // Hold the lookup payload
   always_ff @(posedge clock) begin
      if (start) begin
         key_ff <= key;
      end
      if (issue) begin
         pidx_ff <= cnt_ff[IW-1:0];
      end
      if (!start && pend_ff) begin
         if (valid_ff[pidx_ff] && rd_ff.key == key_ff && !hit_ff) begin
            hit_slot_ff <= pidx_ff;
            hit_meta_ff <= rd_ff;
         end
         if (!valid_ff[pidx_ff] && !free_ff) begin
            free_slot_ff <= pidx_ff;
         end
      end
   end

   assign stat.done       = done;
   assign stat.hit        = hit_ff;
   assign stat.free_found = free_ff;
   assign hit_slot        = hit_slot_ff;
   assign free_slot       = free_slot_ff;
   assign hit_meta        = hit_meta_ff;

endmodule

@@ test/resource_state_barrier_tracker_test.sv @@
`timescale 1ns / 1ps

// Predicts tracker responses and checks them in order
class barrier_scoreboard;
   localparam int NUM_RES = 16;
   localparam int NUM_SUB = 16;

   bit               slot_used[NUM_RES];
   logic [31:0]      slot_key[NUM_RES];
   logic [31:0]      slot_whole[NUM_RES];
   bit               slot_split[NUM_RES];
   int unsigned      slot_count[NUM_RES];
   logic [31:0]      slot_subs[NUM_RES][NUM_SUB];
   rsbt_pkg::rsp_type pending_rsp[$];
   int               error_count;

   function int find_key(logic [31:0] key);
      for (int i = 0; i < NUM_RES; i++)
         if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   function void fill_slot(int s, logic [31:0] st);
      slot_whole[s] = st;
      for (int i = 0; i < slot_count[s]; i++) slot_subs[s][i] = st;
      slot_split[s] = 0;
   endfunction

   function void write_sub(int s, int idx, logic [31:0] st);
      bit uniform;
      uniform = 1;
      slot_subs[s][idx] = st;
      slot_split[s] = 1;
      for (int i = 1; i < slot_count[s]; i++)
         if (slot_subs[s][i] != slot_subs[s][0]) uniform = 0;
      if (uniform) begin
         slot_whole[s] = slot_subs[s][0];
         slot_split[s] = 0;
      end
   endfunction

   // Note an accepted transaction and queue its expected responses
   function void note_request(rsbt_pkg::req_type r);
      rsbt_pkg::rsp_type bars[$];
      rsbt_pkg::rsp_type b;
      logic [2:0]  status;
      logic [31:0] rd;
      logic [31:0] cur;
      int          s;
      int unsigned cnt;
      bit          tr;
      status = rsbt_pkg::ST_OK;
      rd = '0;
      s = (r.resource_key != 0) ? find_key(r.resource_key) : -1;
      if (r.op <= rsbt_pkg::OP_TRANS && r.resource_key == 0) begin
         status = rsbt_pkg::ST_UNTRACKED;
      end else if (r.op == rsbt_pkg::OP_TRACK) begin
         cnt = (r.subresource_count == 0) ? 1 : r.subresource_count;
         if (cnt > NUM_SUB) begin
            status = rsbt_pkg::ST_COUNT;
         end else begin
            if (s < 0)
               for (int i = NUM_RES - 1; i >= 0; i--) if (!slot_used[i]) s = i;
            if (s < 0) begin
               status = rsbt_pkg::ST_FULL;
            end else begin
               slot_used[s] = 1;
               slot_key[s] = r.resource_key;
               slot_count[s] = cnt;
               fill_slot(s, r.state_value);
            end
         end
      end else if (r.op <= rsbt_pkg::OP_TRANS && s < 0) begin
         status = rsbt_pkg::ST_UNTRACKED;
      end else if (r.op == rsbt_pkg::OP_UNTRACK) begin
         slot_used[s] = 0;
      end else if (r.op == rsbt_pkg::OP_QUERY) begin
         rd = slot_whole[s];
         if (!r.all_subresources && r.subresource_index >= slot_count[s])
            status = rsbt_pkg::ST_RANGE;
         else if (!r.all_subresources && slot_split[s])
            rd = slot_subs[s][r.subresource_index];
      end else if (r.op == rsbt_pkg::OP_SET) begin
         if (r.all_subresources) fill_slot(s, r.state_value);
         else if (r.subresource_index < slot_count[s])
            write_sub(s, r.subresource_index, r.state_value);
         else status = rsbt_pkg::ST_RANGE;
      end else if (r.op == rsbt_pkg::OP_TRANS) begin
         b = '0;
         b.barrier_valid = 1;
         b.state_after = r.state_value;
         if (r.all_subresources) begin
            if (slot_split[s]) begin
               for (int i = 0; i < slot_count[s]; i++)
                  if (slot_subs[s][i] != r.state_value) begin
                     b.barrier_subresource = 4'(i);
                     b.state_before = slot_subs[s][i];
                     bars.insert(bars.size(), b);
                  end
               fill_slot(s, r.state_value);
            end else if (slot_whole[s] != r.state_value) begin
               b.barrier_all = 1;
               b.state_before = slot_whole[s];
               bars.insert(bars.size(), b);
               fill_slot(s, r.state_value);
            end
         end else if (r.subresource_index < slot_count[s]) begin
            cur = slot_split[s] ? slot_subs[s][r.subresource_index] : slot_whole[s];
            if (cur != r.state_value) begin
               b.barrier_subresource = r.subresource_index;
               b.state_before = cur;
               bars.insert(bars.size(), b);
               write_sub(s, r.subresource_index, r.state_value);
            end
         end else begin
            status = rsbt_pkg::ST_RANGE;
         end
      end
      if (bars.size() == 0) bars.insert(0, '0);
      tr = (r.resource_key != 0) && (find_key(r.resource_key) >= 0);
      foreach (bars[k]) begin
         bars[k].status = status;
         bars[k].tracked = tr;
         bars[k].read_state = rd;
         bars[k].last = (k == bars.size() - 1);
         pending_rsp.insert(pending_rsp.size(), bars[k]);
      end
   endfunction

   // Compare one response against the oldest expectation
   function void check_response(rsbt_pkg::rsp_type act);
      rsbt_pkg::rsp_type exp_rsp;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected response %h", $time, act);
         error_count++;
         return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (exp_rsp !== act) begin
         $display("%0t: mismatch expected %h actual %h", $time, exp_rsp, act);
         error_count++;
      end
   endfunction
endclass

module resource_state_barrier_tracker_test;
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rsbt_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsbt_pkg::rsp_type rsp_data;

   barrier_scoreboard tracker_sb;
   bit                quiet_phase;
   bit                hold_rsp;
   logic [31:0]       key_pool[8];

   resource_state_barrier_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run length
   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

   // Check responses and note accepted requests at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker_sb.check_response(rsp_data);
         if (req_valid && req_ready) tracker_sb.note_request(req_data);
      end
   end

   // Receiver: random stalls, none in the quiet phase, long hold on request
   initial begin
      rsp_ready = 0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_ready <= quiet_phase || ($urandom_range(99) >= 13);
         @(posedge clock);
      end
   end

   // Offer one transaction and hold it until accepted
   task send_request(rsbt_pkg::req_type r);
      while (!quiet_phase && $urandom_range(99) < 13) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task send_fields(logic [2:0] op, logic [31:0] key, logic [31:0] st, logic [3:0] idx,
                    logic all, logic [4:0] cnt);
      rsbt_pkg::req_type r;
      r.op = op;
      r.resource_key = key;
      r.state_value = st;
      r.subresource_index = idx;
      r.all_subresources = all;
      r.subresource_count = cnt;
      send_request(r);
   endtask

   task send_random;
      rsbt_pkg::req_type r;
      int pick;
      r.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      pick = $urandom_range(19);
      r.resource_key = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom() :
                       key_pool[$urandom_range(7)];
      // Few states so transitions and merges happen often
      r.state_value = ($urandom_range(3) == 0) ? $urandom() : (32'd1 << $urandom_range(3));
      r.subresource_index = 4'($urandom_range(15));
      r.all_subresources = ($urandom_range(3) == 0);
      r.subresource_count = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                            5'($urandom_range(4));
      if ($urandom_range(4) == 0) r.subresource_count = 5'd16;
      if (r.op != rsbt_pkg::OP_TRACK && r.resource_key != 0 && $urandom_range(1))
         r.subresource_index = 4'($urandom_range(3));
      send_request(r);
   endtask

   initial begin
      int wait_cycles;
      tracker_sb = new();
      quiet_phase = 0;
      hold_rsp = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom() | 32'h1;
      key_pool[7] = 32'hFFFF_FFFF;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: null key, extremes, every op and special case
      send_fields(rsbt_pkg::OP_TRACK, 32'd0, 32'h1, 4'd0, 1'b0, 5'd1);
      send_fields(rsbt_pkg::OP_QUERY, 32'h5, 32'h0, 4'd0, 1'b1, 5'd0);
      send_fields(rsbt_pkg::OP_TRACK, 32'h5, 32'h0, 4'd0, 1'b0, 5'd17);
      send_fields(rsbt_pkg::OP_TRACK, 32'h5, 32'hFFFF_FFFF, 4'd0, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_TRACK, 32'hFFFF_FFFF, 32'h1, 4'd0, 1'b0, 5'd16);
      send_fields(rsbt_pkg::OP_QUERY, 32'h5, 32'h0, 4'd1, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_SET, 32'hFFFF_FFFF, 32'h2, 4'd15, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0, 4'd15, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_TRANS, 32'hFFFF_FFFF, 32'h4, 4'd0, 1'b1, 5'd0);
      send_fields(rsbt_pkg::OP_TRANS, 32'hFFFF_FFFF, 32'h8, 4'd0, 1'b1, 5'd0);
      send_fields(rsbt_pkg::OP_TRANS, 32'hFFFF_FFFF, 32'h8, 4'd3, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_TRANS, 32'hFFFF_FFFF, 32'h10, 4'd3, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_TRANS, 32'h5, 32'h1, 4'd2, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_SET, 32'h5, 32'h1, 4'd2, 1'b0, 5'd0);
      send_fields(3'd7, 32'h5, 32'h0, 4'd0, 1'b0, 5'd0);
      send_fields(3'd5, 32'h0, 32'h0, 4'd0, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_TRACK, 32'h5, 32'h3, 4'd0, 1'b0, 5'd2);
      for (int i = 0; i < 15; i++)
         send_fields(rsbt_pkg::OP_TRACK, 32'h100 + i, 32'h0, 4'd0, 1'b0, 5'd1);
      send_fields(rsbt_pkg::OP_UNTRACK, 32'h5, 32'h0, 4'd0, 1'b0, 5'd0);
      send_fields(rsbt_pkg::OP_UNTRACK, 32'h5, 32'h0, 4'd0, 1'b0, 5'd0);
      for (int i = 0; i < 16; i++)
         send_fields(rsbt_pkg::OP_UNTRACK, (i < 15) ? 32'h100 + i : 32'hFFFF_FFFF,
                     32'h0, 4'd0, 1'b0, 5'd0);

      // Random: a quiet stretch, a long receiver hold, then mixed idling
      for (int n = 0; n < 330; n++) begin
         quiet_phase = (n >= 60 && n < 120);
         if (n == 200) hold_rsp = 1;
         send_random();
      end
      req_valid <= 0;

      wait_cycles = 0;
      while (tracker_sb.pending_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (tracker_sb.pending_rsp.size() == 0 && tracker_sb.error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

@@ resource_state_barrier_tracker.f @@
hdl/rsbt_pkg.sv
hdl/rsbt_slot_lookup.sv
hdl/resource_state_barrier_tracker.sv
test/resource_state_barrier_tracker_test.sv
